// File: hdl/odpr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package odpr_pkg;

  localparam int unsigned COL_W = 16;
  localparam int unsigned ROW_W = 16;
  localparam int unsigned PIX_W = 8;
  localparam int unsigned REP_W = 7;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [3:0] THRESH_FLIP = 4'hF;
  localparam logic [7:0] ROW_BIT_TOP = 8'h80;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_GREYSCALE = 2'd1,
    REG_DITHER_LO = 2'd2,
    REG_DITHER_HI = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic out_valid;
    logic load;
    logic advance;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last;
  } dp_status_t;

  typedef struct packed {
    logic [COL_W-1:0] column;
    logic [7:0]       row_bit;
    logic             set_black;
    logic             set_yellow;
    logic             set_magenta;
    logic             set_cyan;
    logic             last;
  } result_t;

  typedef struct packed {
    logic set_black;
    logic set_yellow;
    logic set_magenta;
    logic set_cyan;
  } planes_t;

  function automatic planes_t plane_decide(
    input logic [3:0]       threshold,
    input logic             greyscale,
    input logic [63:0]      rows_lo,
    input logic [63:0]      rows_hi,
    input logic [1:0]       row_low,
    input logic [1:0]       col_low,
    input logic [PIX_W-1:0] blk,
    input logic [PIX_W-1:0] yel,
    input logic [PIX_W-1:0] mag,
    input logic [PIX_W-1:0] cya
  );
    logic [3:0]  idx;
    logic [63:0] word;
    logic [7:0]  entry;
    planes_t     p;
    idx   = {row_low, col_low};
    word  = idx[3] ? rows_hi : rows_lo;
    entry = word[{idx[2:0], 3'b000} +: 8];
    p     = '0;
    if (threshold != 4'd0) begin
      p.set_black = blk > {4'd0, threshold ^ THRESH_FLIP};
    end else if (greyscale) begin
      p.set_black = blk > entry;
    end else if (blk > entry) begin
      p.set_black = 1'b1;
    end else begin
      p.set_yellow  = yel > entry;
      p.set_magenta = mag > entry;
      p.set_cyan    = cya > entry;
    end
    return p;
  endfunction

endpackage
`default_nettype wire

// File: hdl/odpr_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface odpr_in_if
  import odpr_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             row_start;
  logic [COL_W-1:0] start_x;
  logic [ROW_W-1:0] row;
  logic [PIX_W-1:0] black;
  logic [PIX_W-1:0] yellow;
  logic [PIX_W-1:0] magenta;
  logic [PIX_W-1:0] cyan;
  logic [REP_W-1:0] repeat_req;

  modport source (
    output valid, row_start, start_x, row, black, yellow, magenta, cyan, repeat_req,
    input  ready
  );
  modport sink (
    input  valid, row_start, start_x, row, black, yellow, magenta, cyan, repeat_req,
    output ready
  );
endinterface

interface odpr_out_if
  import odpr_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [COL_W-1:0] column;
  logic [7:0]       row_bit;
  logic             set_black;
  logic             set_yellow;
  logic             set_magenta;
  logic             set_cyan;
  logic             last;

  modport source (
    output valid, column, row_bit, set_black, set_yellow, set_magenta, set_cyan, last,
    input  ready
  );
  modport sink (
    input  valid, column, row_bit, set_black, set_yellow, set_magenta, set_cyan, last,
    output ready
  );
endinterface
`default_nettype wire

// File: hdl/odpr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module odpr_ctrl
  import odpr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       out_ready,
  input  wire dp_status_t status,
  output ctrl_cmd_t       cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_ready && status.last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.in_ready = 1'b1;
        cmd.load     = in_valid;
      end
      ST_EMIT: begin
        cmd.out_valid = 1'b1;
        cmd.advance   = out_ready;
      end
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: hdl/odpr_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module odpr_dp
  import odpr_pkg::*;
#(
  parameter int unsigned MAX_REPEAT = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  row_start,
  input  wire logic [COL_W-1:0]      start_x,
  input  wire logic [ROW_W-1:0]      row,
  input  wire logic [PIX_W-1:0]      black,
  input  wire logic [PIX_W-1:0]      yellow,
  input  wire logic [PIX_W-1:0]      magenta,
  input  wire logic [PIX_W-1:0]      cyan,
  input  wire logic [REP_W-1:0]      repeat_req,
  input  wire ctrl_cmd_t             cmd,
  output dp_status_t                 status,
  output result_t                    result
);

  localparam logic [REP_W-1:0] REP_MAX = REP_W'(MAX_REPEAT);

  logic [3:0]       threshold;
  logic             greyscale;
  logic [63:0]      rows_lo;
  logic [63:0]      rows_hi;

  logic [COL_W-1:0] column;
  logic [REP_W-1:0] remain;
  logic [1:0]       row_low;
  logic [PIX_W-1:0] blk;
  logic [PIX_W-1:0] yel;
  logic [PIX_W-1:0] mag;
  logic [PIX_W-1:0] cya;
  logic [7:0]       row_bit;
  planes_t          planes;

  logic [REP_W-1:0] reps;
  logic [COL_W-1:0] load_col;
  logic [COL_W-1:0] step_col;
  planes_t          load_planes;
  planes_t          step_planes;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= '0;
      greyscale <= 1'b0;
      rows_lo   <= '0;
      rows_hi   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_THRESHOLD: threshold <= cfg_data[3:0];
        REG_GREYSCALE: greyscale <= cfg_data[0];
        REG_DITHER_LO: rows_lo   <= cfg_data;
        REG_DITHER_HI: rows_hi   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (repeat_req == '0) begin
      reps = REP_W'(1);
    end else if (repeat_req > REP_MAX) begin
      reps = REP_MAX;
    end else begin
      reps = repeat_req;
    end
    load_col    = row_start ? start_x : column;
    step_col    = column + COL_W'(1);
    load_planes = plane_decide(threshold, greyscale, rows_lo, rows_hi, row[1:0],
                               load_col[1:0], black, yellow, magenta, cyan);
    step_planes = plane_decide(threshold, greyscale, rows_lo, rows_hi, row_low,
                               step_col[1:0], blk, yel, mag, cya);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
    end else if (cmd.load) begin
      column <= load_col;
    end else if (cmd.advance) begin
      column <= step_col;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      remain  <= reps;
      row_low <= row[1:0];
      blk     <= black;
      yel     <= yellow;
      mag     <= magenta;
      cya     <= cyan;
      row_bit <= ROW_BIT_TOP >> row[2:0];
      planes  <= load_planes;
    end else if (cmd.advance) begin
      remain  <= remain - REP_W'(1);
      planes  <= step_planes;
    end
  end

  assign status.last = (remain == REP_W'(1));

  always_comb begin
    result.column      = column;
    result.row_bit     = row_bit;
    result.set_black   = planes.set_black;
    result.set_yellow  = planes.set_yellow;
    result.set_magenta = planes.set_magenta;
    result.set_cyan    = planes.set_cyan;
    result.last        = status.last;
  end

endmodule
`default_nettype wire

// File: hdl/ordered_dither_plane_render.sv
`timescale 1ns / 1ps
`default_nettype none
// Expands each source pixel into repeat_req printer pixels (0 counts as 1, values above
// MAX_REPEAT saturate) and marks which CMYK planes get the row bit at each column, by
// threshold, greyscale 4x4 ordered dither or colour dither. A source transaction is
// taken only while the controller is idle, then one result is offered per cycle while
// the sink is ready; no new transaction is taken until the last result is accepted.
// The datapath output register holds the offered result while the sink is not ready.
module ordered_dither_plane_render
  import odpr_pkg::*;
#(
  parameter int unsigned MAX_REPEAT = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  odpr_in_if.sink                    src,
  odpr_out_if.source                 dst
);

  ctrl_cmd_t  cmd;
  dp_status_t status;
  result_t    result;

  odpr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (src.valid),
    .out_ready (dst.ready),
    .status    (status),
    .cmd       (cmd)
  );

  odpr_dp #(
    .MAX_REPEAT (MAX_REPEAT)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .row_start  (src.row_start),
    .start_x    (src.start_x),
    .row        (src.row),
    .black      (src.black),
    .yellow     (src.yellow),
    .magenta    (src.magenta),
    .cyan       (src.cyan),
    .repeat_req (src.repeat_req),
    .cmd        (cmd),
    .status     (status),
    .result     (result)
  );

  assign src.ready       = cmd.in_ready;
  assign dst.valid       = cmd.out_valid;
  assign dst.column      = result.column;
  assign dst.row_bit     = result.row_bit;
  assign dst.set_black   = result.set_black;
  assign dst.set_yellow  = result.set_yellow;
  assign dst.set_magenta = result.set_magenta;
  assign dst.set_cyan    = result.set_cyan;
  assign dst.last        = result.last;

endmodule
`default_nettype wire

// File: dv/ordered_dither_plane_render_tb.sv
`timescale 1ns / 1ps
module ordered_dither_plane_render_tb;
  import odpr_pkg::*;

  localparam int unsigned REPEAT_CAP = 64;
  localparam int unsigned HOLD_CYCLES = 150;

  typedef struct packed {
    logic             row_start;
    logic [COL_W-1:0] start_x;
    logic [ROW_W-1:0] row;
    logic [PIX_W-1:0] black;
    logic [PIX_W-1:0] yellow;
    logic [PIX_W-1:0] magenta;
    logic [PIX_W-1:0] cyan;
    logic [REP_W-1:0] repeat_req;
  } pixel_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  cfg_reg_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  odpr_in_if  src_if ();
  odpr_out_if dst_if ();

  ordered_dither_plane_render #(
    .MAX_REPEAT(REPEAT_CAP)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .src      (src_if),
    .dst      (dst_if)
  );

  logic [3:0]       thr_reg;
  logic             grey_reg;
  logic [63:0]      dith_lo;
  logic [63:0]      dith_hi;
  logic [COL_W-1:0] col_ctr;
  result_t          plot_q[$];

  int unsigned fail_count;
  int unsigned pixels_sent;
  bit          calm;
  bit          stall_req;
  int unsigned hold_left;
  int unsigned gap_left;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void expand_pixel(pixel_t p);
    int unsigned reps;
    logic [3:0]  slot;
    logic [63:0] word;
    logic [7:0]  level;
    result_t     r;
    reps = (p.repeat_req == 0) ? 1 :
           ((p.repeat_req > REPEAT_CAP) ? REPEAT_CAP : 32'(p.repeat_req));
    if (p.row_start) col_ctr = p.start_x;
    for (int unsigned k = 0; k < reps; k++) begin
      slot  = {p.row[1:0], col_ctr[1:0]};
      word  = slot[3] ? dith_hi : dith_lo;
      level = word[slot[2:0]*8 +: 8];
      r = '0;
      r.column  = col_ctr;
      r.row_bit = ROW_BIT_TOP >> p.row[2:0];
      if (thr_reg != 4'd0) begin
        r.set_black = p.black > {4'd0, thr_reg ^ THRESH_FLIP};
      end else if (grey_reg) begin
        r.set_black = p.black > level;
      end else if (p.black > level) begin
        r.set_black = 1'b1;
      end else begin
        r.set_yellow  = p.yellow > level;
        r.set_magenta = p.magenta > level;
        r.set_cyan    = p.cyan > level;
      end
      r.last = (k + 1 == reps);
      plot_q.push_back(r);
      col_ctr = col_ctr + 1'b1;
    end
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t %s mismatch: expected %0d actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    pixel_t  p;
    result_t want;
    if (!rst) begin
      if (src_if.valid && src_if.ready) begin
        p.row_start  = src_if.row_start;
        p.start_x    = src_if.start_x;
        p.row        = src_if.row;
        p.black      = src_if.black;
        p.yellow     = src_if.yellow;
        p.magenta    = src_if.magenta;
        p.cyan       = src_if.cyan;
        p.repeat_req = src_if.repeat_req;
        expand_pixel(p);
      end
      if (dst_if.valid && dst_if.ready) begin
        if (plot_q.size() == 0) begin
          $display("%0t unexpected result: expected none actual column %0d", $time,
                   dst_if.column);
          fail_count++;
        end else begin
          want = plot_q.pop_front();
          check_field("column", 32'(want.column), 32'(dst_if.column));
          check_field("row_bit", 32'(want.row_bit), 32'(dst_if.row_bit));
          check_field("set_black", 32'(want.set_black), 32'(dst_if.set_black));
          check_field("set_yellow", 32'(want.set_yellow), 32'(dst_if.set_yellow));
          check_field("set_magenta", 32'(want.set_magenta), 32'(dst_if.set_magenta));
          check_field("set_cyan", 32'(want.set_cyan), 32'(dst_if.set_cyan));
          check_field("last", 32'(want.last), 32'(dst_if.last));
        end
      end
    end
  end

  always @(negedge clk) begin
    if (stall_req) begin
      hold_left = HOLD_CYCLES;
      stall_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      dst_if.ready = 1'b0;
    end else if (gap_left > 0) begin
      gap_left--;
      dst_if.ready = 1'b0;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      gap_left = $urandom_range(0, 3);
      dst_if.ready = 1'b0;
    end else begin
      dst_if.ready = 1'b1;
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [63:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_THRESHOLD: thr_reg  = value[3:0];
      REG_GREYSCALE: grey_reg = value[0];
      REG_DITHER_LO: dith_lo  = value;
      REG_DITHER_HI: dith_hi  = value;
      default: ;
    endcase
  endtask

  task automatic send_pixel(pixel_t p);
    int unsigned gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
    @(negedge clk);
    if (gap > 0) begin
      src_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    src_if.row_start  = p.row_start;
    src_if.start_x    = p.start_x;
    src_if.row        = p.row;
    src_if.black      = p.black;
    src_if.yellow     = p.yellow;
    src_if.magenta    = p.magenta;
    src_if.cyan       = p.cyan;
    src_if.repeat_req = p.repeat_req;
    src_if.valid      = 1'b1;
    do @(posedge clk); while (!src_if.ready);
    pixels_sent++;
  endtask

  task automatic settle();
    @(negedge clk);
    src_if.valid = 1'b0;
    while (plot_q.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic pixel_t mk_pixel(logic rs, logic [15:0] sx, logic [15:0] y,
                                      logic [7:0] k, logic [7:0] ye, logic [7:0] m,
                                      logic [7:0] c, logic [6:0] rep);
    pixel_t p;
    p.row_start  = rs;
    p.start_x    = sx;
    p.row        = y;
    p.black      = k;
    p.yellow     = ye;
    p.magenta    = m;
    p.cyan       = c;
    p.repeat_req = rep;
    return p;
  endfunction

  function automatic logic [7:0] rand_level();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t p;
    p.row_start = 1'b0;
    p.start_x   = ($urandom_range(0, 7) == 0) ? 16'(16'hFFFF - $urandom_range(0, 5))
                                              : 16'($urandom);
    p.row       = 16'($urandom);
    p.black     = rand_level();
    p.yellow    = rand_level();
    p.magenta   = rand_level();
    p.cyan      = rand_level();
    case ($urandom_range(0, 11))
      0:       p.repeat_req = 7'($urandom_range(0, 127));
      1:       p.repeat_req = 7'($urandom_range(33, 64));
      default: p.repeat_req = 7'($urandom_range(1, 6));
    endcase
    return p;
  endfunction

  task automatic send_row(int unsigned len);
    logic [15:0] y;
    pixel_t      p;
    y = 16'($urandom);
    for (int unsigned i = 0; i < len; i++) begin
      p = rand_pixel();
      p.row = y;
      p.row_start = (i == 0);
      if ($urandom_range(0, 11) == 0) p.row_start = ~p.row_start;
      send_pixel(p);
    end
  endtask

  task automatic test_threshold_mode();
    write_reg(REG_THRESHOLD, 64'd1);
    write_reg(REG_GREYSCALE, 64'd1);
    write_reg(REG_DITHER_LO, {$urandom, $urandom});
    write_reg(REG_DITHER_HI, {$urandom, $urandom});
    send_pixel(mk_pixel(1'b1, 16'h0000, 16'h0000, 8'd14, 8'hFF, 8'hFF, 8'hFF, 7'd1));
    send_pixel(mk_pixel(1'b0, 16'hFFFF, 16'h0007, 8'd15, 8'h00, 8'h00, 8'h00, 7'd2));
    send_pixel(mk_pixel(1'b0, 16'h0000, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 7'd3));
    settle();
    write_reg(REG_THRESHOLD, 64'd15);
    send_pixel(mk_pixel(1'b1, 16'h1234, 16'h0003, 8'd0, 8'hFF, 8'hFF, 8'hFF, 7'd2));
    send_pixel(mk_pixel(1'b0, 16'h0000, 16'h0004, 8'd1, 8'h00, 8'h00, 8'h00, 7'd1));
    settle();
  endtask

  task automatic test_greyscale_dither();
    write_reg(REG_THRESHOLD, 64'd0);
    write_reg(REG_GREYSCALE, 64'd1);
    write_reg(REG_DITHER_LO, 64'h7060_5040_3020_1000);
    write_reg(REG_DITHER_HI, 64'hF0E0_D0C0_B0A0_9080);
    send_pixel(mk_pixel(1'b1, 16'h0000, 16'h0001, 8'h48, 8'hFF, 8'hFF, 8'hFF, 7'd4));
    send_pixel(mk_pixel(1'b1, 16'h0002, 16'h0003, 8'hFF, 8'hFF, 8'h00, 8'hFF, 7'd4));
    send_pixel(mk_pixel(1'b0, 16'h0000, 16'h0002, 8'h00, 8'hFF, 8'hFF, 8'hFF, 7'd4));
    settle();
  endtask

  task automatic test_colour_dither();
    write_reg(REG_GREYSCALE, 64'd0);
    send_pixel(mk_pixel(1'b1, 16'h0000, 16'h0002, 8'h00, 8'hFF, 8'h00, 8'h95, 7'd4));
    send_pixel(mk_pixel(1'b0, 16'h0000, 16'h0002, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 7'd2));
    settle();
    write_reg(REG_DITHER_LO, '1);
    write_reg(REG_DITHER_HI, '1);
    send_pixel(mk_pixel(1'b1, 16'h0010, 16'h0005, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 7'd4));
    settle();
    write_reg(REG_DITHER_LO, '0);
    write_reg(REG_DITHER_HI, '0);
    send_pixel(mk_pixel(1'b1, 16'h0020, 16'h0006, 8'h00, 8'h01, 8'h00, 8'h01, 7'd4));
    settle();
  endtask

  task automatic test_repeat_and_wrap();
    write_reg(REG_DITHER_LO, {$urandom, $urandom});
    write_reg(REG_DITHER_HI, {$urandom, $urandom});
    send_pixel(mk_pixel(1'b1, 16'h0100, 16'h000A, 8'h80, 8'h40, 8'hC0, 8'h20, 7'd0));
    send_pixel(mk_pixel(1'b0, 16'h0000, 16'h000A, 8'h10, 8'hF0, 8'h70, 8'hA0, 7'd1));
    send_pixel(mk_pixel(1'b0, 16'h0000, 16'h000A, 8'h60, 8'h90, 8'h30, 8'hD0, 7'd64));
    send_pixel(mk_pixel(1'b0, 16'h0000, 16'h000A, 8'h20, 8'hE0, 8'h50, 8'h80, 7'd65));
    send_pixel(mk_pixel(1'b0, 16'h0000, 16'h000A, 8'h00, 8'h55, 8'hAA, 8'h7F, 7'd127));
    send_pixel(mk_pixel(1'b1, 16'hFFFE, 16'h000B, 8'h33, 8'hCC, 8'h66, 8'h99, 7'd4));
    send_pixel(mk_pixel(1'b0, 16'h0000, 16'h000B, 8'hC3, 8'h3C, 8'h5A, 8'hA5, 7'd2));
    settle();
  endtask

  task automatic test_sink_backpressure();
    @(posedge clk);
    stall_req = 1'b1;
    send_row(12);
    settle();
  endtask

  task automatic test_source_pause();
    send_row(6);
    settle();
    send_row(6);
    settle();
  endtask

  task automatic test_random_rows();
    int unsigned target;
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      case (ph)
        0: begin
          write_reg(REG_THRESHOLD, 64'd0);
          write_reg(REG_GREYSCALE, 64'd0);
          write_reg(REG_DITHER_LO, {$urandom, $urandom});
          write_reg(REG_DITHER_HI, {$urandom, $urandom});
        end
        1: write_reg(REG_GREYSCALE, 64'd1);
        2: write_reg(REG_THRESHOLD, 64'd15);
        3: write_reg(REG_THRESHOLD, 64'($urandom_range(1, 14)));
        4: begin
          write_reg(REG_THRESHOLD, 64'd0);
          write_reg(REG_GREYSCALE, 64'd0);
          write_reg(REG_DITHER_LO, '1);
          write_reg(REG_DITHER_HI, {$urandom, $urandom});
        end
        default: begin
          write_reg(REG_GREYSCALE, 64'($urandom_range(0, 1)));
          write_reg(REG_DITHER_LO, {$urandom, $urandom});
          write_reg(REG_DITHER_HI, {$urandom, $urandom});
          calm = 1'b1;
        end
      endcase
      if (ph == 2) test_sink_backpressure();
      if (ph == 3) test_source_pause();
      target = pixels_sent + 45;
      while (pixels_sent < target) send_row($urandom_range(1, 8));
    end
    settle();
  endtask

  initial begin
    clk         = 1'b0;
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = REG_THRESHOLD;
    cfg_data    = '0;
    src_if.valid      = 1'b0;
    src_if.row_start  = 1'b0;
    src_if.start_x    = '0;
    src_if.row        = '0;
    src_if.black      = '0;
    src_if.yellow     = '0;
    src_if.magenta    = '0;
    src_if.cyan       = '0;
    src_if.repeat_req = '0;
    dst_if.ready      = 1'b0;
    thr_reg     = '0;
    grey_reg    = 1'b0;
    dith_lo     = '0;
    dith_hi     = '0;
    col_ctr     = '0;
    fail_count  = 0;
    pixels_sent = 0;
    calm        = 1'b0;
    stall_req   = 1'b0;
    hold_left   = 0;
    gap_left    = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_threshold_mode();
    test_greyscale_dither();
    test_colour_dither();
    test_repeat_and_wrap();
    test_random_rows();

    repeat (8) @(posedge clk);
    if (fail_count == 0 && plot_q.size() == 0) begin
      $display("ordered_dither_plane_render regression: pass");
    end else begin
      $display("ordered_dither_plane_render regression: fail");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("ordered_dither_plane_render regression: fail");
    $finish;
  end

endmodule

// File: files.f
hdl/odpr_pkg.sv
hdl/odpr_if.sv
hdl/odpr_ctrl.sv
hdl/odpr_dp.sv
hdl/ordered_dither_plane_render.sv
dv/ordered_dither_plane_render_tb.sv
